@@ sv/wls_pkg.sv @@
// Shared types and constants of the leapfrog wave stencil update block.
package wls_pkg;

	localparam int MAX_ROW_DEF = 128;
	localparam int MAX_ROWS_DEF = 128;
	localparam int MAX_PLANES_DEF = 128;

	localparam int SAMPLE_W = 32;
	localparam int INDEX_W = 21;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int FRAC_SHIFT = 28;

	localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROWS_PER_PLANE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PLANE_COUNT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_THREE_DIM = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_WEIGHT = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_X = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_Y = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_Z = 3'd7;

	localparam logic [7:0] RESET_ROW_LENGTH = 8'd128;
	localparam logic [7:0] RESET_ROWS_PER_PLANE = 8'd128;
	localparam logic [7:0] RESET_PLANE_COUNT = 8'd1;
	localparam logic [31:0] RESET_CENTER_WEIGHT = 32'h2000_0000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] field_now;
		logic signed [SAMPLE_W-1:0] field_before;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] field_next;
		logic [INDEX_W-1:0] point_index;
	} result_t;

endpackage

@@ sv/wls_line.sv @@
// Variable-length sample delay line held in a synchronous memory.
module wls_line import wls_pkg::*; #(
	parameter int DEPTH = MAX_ROW_DEF,
	parameter int LW = $clog2(DEPTH + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  logic [LW-1:0] len,
	input  logic [SAMPLE_W-1:0] din,
	output logic [SAMPLE_W-1:0] dout
);
	localparam int AW = $clog2(DEPTH);

	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [AW-1:0] ptr_q;
	logic [SAMPLE_W-1:0] dout_q;
	logic [LW-1:0] ptr_nx;

	assign ptr_nx = LW'(ptr_q) + LW'(1);
	assign dout = dout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (shift) begin
			if (ptr_nx >= len) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_nx[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			mem[ptr_q] <= din;
			dout_q <= mem[ptr_q];
		end
	end

endmodule

@@ sv/wave_leapfrog_stencil_update.sv @@
// Top level of the leapfrog wave stencil update block.
// Grid points stream in raster order, one transaction per clock, and every
// interior point yields one result after the transaction that completes its
// neighborhood. The current samples pass through a chain of
// memory delay lines (one plane less one row, one row, one row, one plane
// less one row) with the row taps in registers, and the previous-step samples
// through a delay line of one row in 2D or one plane in 3D; each line does one
// read and one write per transaction, which sets the rate of one point per
// clock. A result that waits at the output holds the block only while the
// last pipeline stage also carries a result.
module wave_leapfrog_stencil_update import wls_pkg::*; #(
	parameter int MAX_ROW = MAX_ROW_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_PLANES = MAX_PLANES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  item_t item,
	output logic result_valid,
	input  logic result_stall,
	output result_t result,
	input  logic cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int CW = $clog2(MAX_ROW + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int ZW = $clog2(MAX_PLANES + 1);
	localparam int DW = $clog2(MAX_ROW * MAX_ROWS + 1);
	localparam int POSW = $clog2(MAX_ROW * MAX_ROWS * MAX_PLANES + 1);
	localparam int A_DEPTH = MAX_ROW * (MAX_ROWS - 1);
	localparam int A_LW = $clog2(A_DEPTH + 1);
	localparam int B_LW = $clog2(MAX_ROW + 1);
	localparam int E_DEPTH = MAX_ROW * MAX_ROWS;
	localparam int E_LW = $clog2(E_DEPTH + 1);

	logic [7:0] row_length_q, rows_per_plane_q, plane_count_q;
	logic three_dim_q;
	logic signed [31:0] center_weight_q, weight_x_q, weight_y_q, weight_z_q;

	logic [CW-1:0] rl, col_q, col;
	logic [RW-1:0] rp, row_q, row;
	logic [ZW-1:0] pc, pl_q, pl;
	logic [POSW-1:0] pos_q, pos;
	logic [DW-1:0] d, len_a, d_tap;
	logic oor, emit, acc, en;
	logic col_last, row_last, pl_last;
	logic [INDEX_W-1:0] idx;

	logic [SAMPLE_W-1:0] cur_s1, a_out, b_out, c_out, d_out, e_out, b_in;
	logic [SAMPLE_W-1:0] r1_q, r2_q;
	logic [INDEX_W-1:0] idx_s1;
	logic v_s1;

	logic signed [31:0] c_s2, bef_s2, bef_s3, bef_s4;
	logic signed [32:0] x_s2, y_s2, z_s2;
	logic [INDEX_W-1:0] idx_s2, idx_s3, idx_s4, idx_s5;
	logic v_s2, v_s3, v_s4, v_s5;
	logic signed [63:0] pc_s3;
	logic signed [64:0] px_s3, py_s3, pz_s3;
	logic signed [65:0] pa_s4, pb_s4;
	logic signed [66:0] tot;
	logic signed [39:0] r_s5;
	logic signed [31:0] sat;

	logic result_valid_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= RESET_ROW_LENGTH;
			rows_per_plane_q <= RESET_ROWS_PER_PLANE;
			plane_count_q <= RESET_PLANE_COUNT;
			three_dim_q <= 1'b0;
			center_weight_q <= RESET_CENTER_WEIGHT;
			weight_x_q <= '0;
			weight_y_q <= '0;
			weight_z_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ROW_LENGTH: row_length_q <= cfg_data[7:0];
				REG_ROWS_PER_PLANE: rows_per_plane_q <= cfg_data[7:0];
				REG_PLANE_COUNT: plane_count_q <= cfg_data[7:0];
				REG_THREE_DIM: three_dim_q <= cfg_data[0];
				REG_CENTER_WEIGHT: center_weight_q <= cfg_data;
				REG_WEIGHT_X: weight_x_q <= cfg_data;
				REG_WEIGHT_Y: weight_y_q <= cfg_data;
				REG_WEIGHT_Z: weight_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int'(row_length_q) < 3) rl = CW'(3);
		else if (int'(row_length_q) > MAX_ROW) rl = CW'(MAX_ROW);
		else rl = CW'(row_length_q);
		if (int'(rows_per_plane_q) < 3) rp = RW'(3);
		else if (int'(rows_per_plane_q) > MAX_ROWS) rp = RW'(MAX_ROWS);
		else rp = RW'(rows_per_plane_q);
		if (int'(plane_count_q) < 1) pc = ZW'(1);
		else if (int'(plane_count_q) > MAX_PLANES) pc = ZW'(MAX_PLANES);
		else pc = ZW'(plane_count_q);
	end

	assign d = DW'(rl) * DW'(rp);
	assign len_a = d - DW'(rl);
	assign d_tap = three_dim_q ? d : DW'(rl);

	assign en = !(result_valid_q && result_stall && v_s5);
	assign item_stall = !en;
	assign acc = item_valid && en;

	assign oor = (col_q >= rl) || (row_q >= rp) || (pl_q >= pc);
	assign col = oor ? '0 : col_q;
	assign row = oor ? '0 : row_q;
	assign pl = oor ? '0 : pl_q;
	assign pos = oor ? '0 : pos_q;

	assign col_last = (CW + 1)'(col) + (CW + 1)'(1) >= (CW + 1)'(rl);
	assign row_last = (RW + 1)'(row) + (RW + 1)'(1) >= (RW + 1)'(rp);
	assign pl_last = (ZW + 1)'(pl) + (ZW + 1)'(1) >= (ZW + 1)'(pc);

	always_comb begin
		if (three_dim_q) begin
			emit = (col != '0) && ((CW + 1)'(col) + (CW + 1)'(2) <= (CW + 1)'(rl))
				&& (row != '0) && ((RW + 1)'(row) + (RW + 1)'(2) <= (RW + 1)'(rp))
				&& (pl >= ZW'(2));
		end else begin
			emit = (col != '0) && ((CW + 1)'(col) + (CW + 1)'(2) <= (CW + 1)'(rl))
				&& (row >= RW'(2));
		end
	end

	assign idx = INDEX_W'(32'(pos) - 32'(d_tap));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pl_q <= '0;
			pos_q <= '0;
		end else if (acc) begin
			if (col_last) begin
				col_q <= '0;
				if (row_last) begin
					row_q <= '0;
					pl_q <= pl_last ? '0 : pl + ZW'(1);
				end else begin
					row_q <= row + RW'(1);
					pl_q <= pl;
				end
			end else begin
				col_q <= col + CW'(1);
				row_q <= row;
				pl_q <= pl;
			end
			pos_q <= (col_last && row_last && pl_last) ? '0 : pos + POSW'(1);
		end
	end

	assign b_in = three_dim_q ? a_out : cur_s1;

	wls_line #(.DEPTH(A_DEPTH)) u_line_a (
		.clk(clk), .arst_n(arst_n), .shift(acc && three_dim_q),
		.len(A_LW'(len_a)), .din(item.field_now), .dout(a_out)
	);

	wls_line #(.DEPTH(MAX_ROW)) u_line_b (
		.clk(clk), .arst_n(arst_n), .shift(acc),
		.len(B_LW'(rl - CW'(2))), .din(b_in), .dout(b_out)
	);

	wls_line #(.DEPTH(MAX_ROW)) u_line_c (
		.clk(clk), .arst_n(arst_n), .shift(acc),
		.len(B_LW'(rl - CW'(2))), .din(r2_q), .dout(c_out)
	);

	wls_line #(.DEPTH(A_DEPTH)) u_line_d (
		.clk(clk), .arst_n(arst_n), .shift(acc && three_dim_q),
		.len(A_LW'(len_a - DW'(1))), .din(c_out), .dout(d_out)
	);

	wls_line #(.DEPTH(E_DEPTH)) u_line_e (
		.clk(clk), .arst_n(arst_n), .shift(acc),
		.len(E_LW'(d_tap)), .din(item.field_before), .dout(e_out)
	);

	always_ff @(posedge clk) begin
		if (acc) begin
			cur_s1 <= item.field_now;
			r1_q <= b_out;
			r2_q <= r1_q;
			idx_s1 <= idx;
		end
		if (en) begin
			c_s2 <= $signed(r1_q);
			x_s2 <= $signed({b_out[31], b_out}) + $signed({r2_q[31], r2_q});
			if (three_dim_q) begin
				y_s2 <= $signed({a_out[31], a_out}) + $signed({c_out[31], c_out});
				z_s2 <= $signed({cur_s1[31], cur_s1}) + $signed({d_out[31], d_out});
			end else begin
				y_s2 <= $signed({cur_s1[31], cur_s1}) + $signed({c_out[31], c_out});
				z_s2 <= '0;
			end
			bef_s2 <= $signed(e_out);
			idx_s2 <= idx_s1;
			pc_s3 <= c_s2 * center_weight_q;
			px_s3 <= x_s2 * weight_x_q;
			py_s3 <= y_s2 * weight_y_q;
			pz_s3 <= z_s2 * weight_z_q;
			bef_s3 <= bef_s2;
			idx_s3 <= idx_s2;
			pa_s4 <= 66'(pc_s3) + 66'(px_s3);
			pb_s4 <= 66'(py_s3) + 66'(pz_s3);
			bef_s4 <= bef_s3;
			idx_s4 <= idx_s3;
			r_s5 <= 40'(tot >>> FRAC_SHIFT) - 40'(bef_s4);
			idx_s5 <= idx_s4;
		end
	end

	assign tot = 67'(pa_s4) + 67'(pb_s4) + (67'(1) <<< (FRAC_SHIFT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc && emit;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		if (r_s5 > 40'sd2147483647) sat = 32'sh7FFF_FFFF;
		else if (r_s5 < -40'sd2147483648) sat = 32'sh8000_0000;
		else sat = r_s5[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en && v_s5) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s5) begin
			result_q.field_next <= sat;
			result_q.point_index <= idx_s5;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

@@ verif/tb_wave_leapfrog_stencil_update.sv @@
// Testbench for the leapfrog wave stencil update block, checked against a self-contained predictor.
`timescale 1ns / 100ps
module tb_wave_leapfrog_stencil_update;
	import wls_pkg::*;

	localparam int PLANE_PTS = MAX_ROW_DEF * MAX_ROWS_DEF;
	localparam int NOW_D = 2 * PLANE_PTS + 1;
	localparam int BEF_D = PLANE_PTS + 1;
	localparam int DRAIN_CYCLES = 24;

	class stencil_scoreboard;
		logic [31:0] regs [8];
		logic [31:0] now_mem [NOW_D];
		logic [31:0] bef_mem [BEF_D];
		int unsigned now_wp, bef_wp, col_pos, row_pos, pl_pos;
		result_t pending_results [$];
		int errors;

		function new();
			regs[REG_ROW_LENGTH] = RESET_ROW_LENGTH;
			regs[REG_ROWS_PER_PLANE] = RESET_ROWS_PER_PLANE;
			regs[REG_PLANE_COUNT] = RESET_PLANE_COUNT;
			regs[REG_THREE_DIM] = 0;
			regs[REG_CENTER_WEIGHT] = RESET_CENTER_WEIGHT;
			regs[REG_WEIGHT_X] = 0;
			regs[REG_WEIGHT_Y] = 0;
			regs[REG_WEIGHT_Z] = 0;
			now_wp = 0;
			bef_wp = 0;
			col_pos = 0;
			row_pos = 0;
			pl_pos = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] v);
			case (idx)
				REG_ROW_LENGTH, REG_ROWS_PER_PLANE, REG_PLANE_COUNT: regs[idx] = v & 32'hFF;
				REG_THREE_DIM: regs[idx] = v & 32'h1;
				default: regs[idx] = v;
			endcase
		endfunction

		function int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function int unsigned extent(int which);
			case (which)
				0: return clampv(regs[REG_ROW_LENGTH], 3, MAX_ROW_DEF);
				1: return clampv(regs[REG_ROWS_PER_PLANE], 3, MAX_ROWS_DEF);
				default: return clampv(regs[REG_PLANE_COUNT], 1, MAX_PLANES_DEF);
			endcase
		endfunction

		function logic [31:0] now_at(int unsigned delay);
			return now_mem[(now_wp + NOW_D - delay) % NOW_D];
		endfunction

		function void mac(logic [31:0] w, logic [31:0] s, inout longint hi, inout longint lo);
			longint p;
			p = longint'($signed(w)) * longint'($signed(s));
			hi += p >>> FRAC_SHIFT;
			lo += p & 64'h0FFF_FFFF;
		endfunction

		function void note(item_t it);
			int unsigned rl, rp, pc, d, crow, cpl;
			bit td, fire;
			longint hi, lo, r;
			result_t res;
			rl = extent(0);
			rp = extent(1);
			pc = extent(2);
			td = regs[REG_THREE_DIM][0];
			if (col_pos >= rl || row_pos >= rp || pl_pos >= pc) begin
				col_pos = 0;
				row_pos = 0;
				pl_pos = 0;
			end
			now_mem[now_wp] = it.field_now;
			bef_mem[bef_wp] = it.field_before;
			if (td) begin
				d = rl * rp;
				fire = col_pos >= 1 && col_pos + 2 <= rl && row_pos >= 1 && row_pos + 2 <= rp
					&& pl_pos >= 2;
			end else begin
				d = rl;
				fire = col_pos >= 1 && col_pos + 2 <= rl && row_pos >= 2;
			end
			if (fire) begin
				hi = 0;
				lo = 0;
				crow = td ? row_pos : row_pos - 1;
				cpl = td ? pl_pos - 1 : pl_pos;
				mac(regs[REG_CENTER_WEIGHT], now_at(d), hi, lo);
				mac(regs[REG_WEIGHT_X], now_at(d + 1), hi, lo);
				mac(regs[REG_WEIGHT_X], now_at(d - 1), hi, lo);
				mac(regs[REG_WEIGHT_Y], now_at(d + rl), hi, lo);
				mac(regs[REG_WEIGHT_Y], now_at(d - rl), hi, lo);
				if (td) begin
					mac(regs[REG_WEIGHT_Z], now_at(2 * d), hi, lo);
					mac(regs[REG_WEIGHT_Z], now_at(0), hi, lo);
				end
				r = hi + ((lo + 64'h0800_0000) >>> FRAC_SHIFT)
					- longint'($signed(bef_mem[(bef_wp + BEF_D - d) % BEF_D]));
				if (r > 64'sd2147483647) r = 64'sd2147483647;
				if (r < -64'sd2147483648) r = -64'sd2147483648;
				res.field_next = r[31:0];
				res.point_index = 21'(((cpl * rp + crow) * rl + col_pos));
				pending_results.push_back(res);
			end
			now_wp = (now_wp + 1) % NOW_D;
			bef_wp = (bef_wp + 1) % BEF_D;
			if (++col_pos >= rl) begin
				col_pos = 0;
				if (++row_pos >= rp) begin
					row_pos = 0;
					if (++pl_pos >= pc) pl_pos = 0;
				end
			end
		endfunction

		function void report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endfunction

		function void check(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result %h", got));
				return;
			end
			want = pending_results.pop_front();
			if (got.field_next !== want.field_next)
				report($sformatf("field_next %h, predicted %h (index %0d)",
					got.field_next, want.field_next, want.point_index));
			if (got.point_index !== want.point_index)
				report($sformatf("point_index %0d, predicted %0d",
					got.point_index, want.point_index));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	stencil_scoreboard sb;
	bit quiet;
	int items_sent;

	wave_leapfrog_stencil_update dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		result_stall <= !quiet && $urandom_range(99) < 18;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) sb.check(result);
	end

	function automatic logic [31:0] pick_sample(int mode);
		logic [31:0] corner [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
			32'h0001_0000};
		case (mode)
			1: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
			2: return corner[$urandom_range(4)];
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_weight();
		if ($urandom_range(1)) return $urandom;
		return 32'($urandom_range(0, 1 << 30)) - 32'(1 << 29);
	endfunction

	task automatic wait_idle();
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(item_t it);
		if (!quiet) begin
			while ($urandom_range(99) < 18) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		sb.note(it);
		items_sent++;
	endtask

	// Whole frames only, so the stores never serve a sample that was not written.
	task automatic run_phase(int rl, int rp, int pc, int td, logic [31:0] cw,
			logic [31:0] wx, logic [31:0] wy, logic [31:0] wz, int frames, int mode,
			bit hold);
		logic [31:0] vals [8];
		int total;
		item_t it;
		item_valid <= 1'b0;
		wait_idle();
		vals = '{rl, rp, pc, td, cw, wx, wy, wz};
		for (int i = 0; i < 8; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= CFG_INDEX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_reg(CFG_INDEX_W'(i), vals[i]);
		end
		cfg_write <= 1'b0;
		total = frames * sb.extent(0) * sb.extent(1) * sb.extent(2);
		for (int k = 0; k < total; k++) begin
			if (hold && k == total / 2) begin
				item_valid <= 1'b0;
				while (sb.pending_results.size() != 0) @(posedge clk);
			end
			it.field_now = pick_sample(mode);
			it.field_before = pick_sample(mode);
			send_item(it);
		end
		item_valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		items_sent = 0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		result_stall <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_phase(3, 3, 1, 0, RESET_CENTER_WEIGHT, 0, 0, 0, 2, 2, 0);
		run_phase(5, 4, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 2, 0);
		run_phase(3, 3, 3, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			1, 2, 0);
		run_phase(3, 3, 0, 1, pick_weight(), pick_weight(), pick_weight(), pick_weight(),
			1, 0, 0);
		quiet = 1'b1;
		run_phase(255, 3, 1, 0, pick_weight(), pick_weight(), pick_weight(), 0, 1, 0, 0);
		quiet = 1'b0;
		run_phase(1, 4, 1, 0, pick_weight(), pick_weight(), pick_weight(), 0, 1, 1, 0);
		run_phase(3, 3, 4, 1, pick_weight(), pick_weight(), pick_weight(), pick_weight(),
			1, 1, 1);
		run_phase(4, 3, 2, 0, 32'h1000_0000, 32'h0800_0000, 32'h0400_0000, 0, 1, 0, 0);
		while (items_sent < 700)
			run_phase($urandom_range(3, 6), $urandom_range(3, 5), $urandom_range(1, 3),
				$urandom_range(1), pick_weight(), pick_weight(), pick_weight(),
				pick_weight(), 1, $urandom_range(2), 0);

		wait_idle();
		if (sb.errors == 0)
			$display("PASS wave_leapfrog_stencil_update");
		else
			$display("FAIL wave_leapfrog_stencil_update");
		$finish;
	end

	initial begin
		#50ms;
		$display("FAIL wave_leapfrog_stencil_update");
		$finish;
	end

endmodule
